// ----- sv/sil_pkg.sv -----
// Shared types, codes and field widths for the sorted insertion list.
`default_nettype none

package sil_pkg;

   // Default sizes of the list.
   localparam int CAPACITY_DEF   = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed widths of the stream fields.
   localparam int CMD_W      = 2;
   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 4;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // Operation codes carried in the request tuser.
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   // Outcome codes of a command.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   // Update strobes broadcast to every cell of the chain.
   typedef struct packed {
      logic ins_en;
      logic rem_en;
   } ctl_type;

endpackage

`default_nettype wire

// ----- sv/sorted_insertion_list_top.sv -----
// Sorted insertion list: a row of compare-and-shift cells behind a stream port.
//
// Usage: a request word carries the command in req_tuser (insert, remove,
// read) and the value and read index in req_tdata. Every request word gives
// exactly one response word holding the read value, the entry count after
// the command and a status (ok, full, not found, index out of range).
// An insert or a remove is applied to all cells at once: each cell compares
// its entry with the value and takes its own, its neighbour's or the new
// value, so a command finishes in the cycle it is accepted.
// The response is registered and appears in the cycle after the request is
// accepted; one word is taken every cycle while the response register is empty or its word is being taken.
// When the receiver stalls, the response register holds its word and
// req_tready stays low until that word is taken.
// Reset empties the list (count zero) and drops any pending response; the
// entry storage itself is not cleared and is only read below the count.
`default_nettype none

module sorted_insertion_list_top
   import sil_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // value[31:0], index[35:32], zero pad
   input  wire logic [CMD_W-1:0]      req_tuser,  // cmd[1:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata   // read_value[31:0], count[36:32],
                                                  // status[38:37], zero pad
);

   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (FILL_W > INDEX_W) ? FILL_W : INDEX_W;

   logic                         accept;
   cmd_type                      cmd;
   logic signed [VALUE_W-1:0]    req_value;
   logic [INDEX_W-1:0]           req_index;
   logic [DATA_WIDTH-1:0]        key;
   ctl_type                      ctrl;
   status_type                   status;
   logic [DATA_WIDTH-1:0]        rd_data;
   logic                         full;
   logic                         found;
   logic                         in_range;

   logic [FILL_W-1:0]            fill_ff;
   logic [FILL_W-1:0]            fill_in;
   logic                         rsp_tvalid_ff;
   logic                         rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]        rsp_tdata_ff;
   logic [RSP_DATA_W-1:0]        rsp_tdata_in;

   logic [DATA_WIDTH-1:0]        entry_w [CAPACITY];
   logic                         gt_w    [CAPACITY];
   logic                         hit_w   [CAPACITY+1];
   logic [DATA_WIDTH-1:0]        rd_w    [CAPACITY+1];

   // Request unpacking.
   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign req_value  = req_tdata[VALUE_W-1:0];
   assign req_index  = req_tdata[VALUE_W +: INDEX_W];
   assign key        = DATA_WIDTH'(req_value);

   // The row of cells; search and read results ripple along it.
   assign hit_w[0] = 1'b0;
   assign rd_w[0]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sil_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .FILL_W     (FILL_W),
         .POSITION   (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .key         (key),
         .rd_index    (req_index),
         .fill        (fill_ff),
         .left_entry  ((i == 0) ? '0 : entry_w[(i == 0) ? 0 : i-1]),
         .left_gt     ((i == 0) ? 1'b0 : gt_w[(i == 0) ? 0 : i-1]),
         .right_entry (entry_w[(i == CAPACITY-1) ? i : i+1]),
         .hit_in      (hit_w[i]),
         .rd_in       (rd_w[i]),
         .entry       (entry_w[i]),
         .gt          (gt_w[i]),
         .hit_out     (hit_w[i+1]),
         .rd_out      (rd_w[i+1])
      );
   end

   assign full     = fill_ff == FILL_W'(CAPACITY);
   assign found    = hit_w[CAPACITY];
   assign in_range = CMP_W'(req_index) < CMP_W'(fill_ff);

   // Command decode: status, read data, new count and cell strobes.
   always_comb begin
      ctrl    = '0;
      status  = ST_OK;
      rd_data = '0;
      fill_in = fill_ff;
      case (cmd)
         CMD_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.ins_en = accept;
               fill_in     = fill_ff + FILL_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (!found) begin
               status = ST_NOT_FOUND;
            end else begin
               ctrl.rem_en = accept;
               fill_in     = fill_ff - FILL_W'(1);
            end
         end
         CMD_READ: begin
            if (!in_range) begin
               status = ST_RANGE;
            end else begin
               rd_data = rd_w[CAPACITY];
            end
         end
         default: begin
         end
      endcase
   end

   // Response register and its valid flag.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (accept) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_DATA_W'({status, COUNT_W'(fill_in), VALUE_W'(rd_data)});
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff <= fill_in;
         end
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

// ----- sv/sil_cell.sv -----
// One cell of the list: holds a single entry and trades it with its neighbours.
`default_nettype none

module sil_cell
   import sil_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FILL_W     = 5,
   parameter int POSITION   = 0
) (
   input  wire logic                  clock,
   input  wire ctl_type               ctrl,
   input  wire logic [DATA_WIDTH-1:0] key,
   input  wire logic [INDEX_W-1:0]    rd_index,
   input  wire logic [FILL_W-1:0]     fill,
   input  wire logic [DATA_WIDTH-1:0] left_entry,
   input  wire logic                  left_gt,
   input  wire logic [DATA_WIDTH-1:0] right_entry,
   input  wire logic                  hit_in,
   input  wire logic [DATA_WIDTH-1:0] rd_in,
   output logic [DATA_WIDTH-1:0]      entry,
   output logic                       gt,
   output logic                       hit_out,
   output logic [DATA_WIDTH-1:0]      rd_out
);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;
   logic                  valid;
   logic                  match;
   logic                  sel;

   // The cell holds a live entry when it lies below the fill count.
   assign valid   = fill > FILL_W'(POSITION);
   assign gt      = valid && ($signed(entry_ff) > $signed(key));
   assign match   = valid && (entry_ff == key);
   assign hit_out = hit_in | match;
   assign entry   = entry_ff;

   // Read select: an OR chain along the row picks the addressed entry.
   assign sel    = valid && (int'(rd_index) == POSITION);
   assign rd_out = rd_in | (sel ? entry_ff : '0);

   // Insert shifts larger entries up; remove closes the gap from above.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt || !valid) begin
            entry_in = key;
         end
      end else if (ctrl.rem_en && hit_out) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ----- sv/sil_check.sv -----
// Port-level checks for the sorted insertion list, bound to the top level.
`default_nettype none

module sil_check
   import sil_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [VALUE_W-1:0]  rsp_value;
   logic [COUNT_W-1:0]  rsp_count;
   logic [STATUS_W-1:0] rsp_status;

   assign rsp_value  = rsp_tdata[VALUE_W-1:0];
   assign rsp_count  = rsp_tdata[VALUE_W +: COUNT_W];
   assign rsp_status = rsp_tdata[VALUE_W+COUNT_W +: STATUS_W];

   // Reset drops any pending response word.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // With the response register empty a request is always taken.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty response register");

   // A full status reports a list at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == ST_FULL) |-> rsp_count == COUNT_W'(CAPACITY))
      else $error("full status with count below capacity");

   // Every failed command carries a zero value.
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status != ST_OK) |-> rsp_value == '0)
      else $error("non-zero value on a failed command");

endmodule

bind sorted_insertion_list_top sil_check #(
   .CAPACITY (CAPACITY)
) u_sil_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- bench/tb_sorted_insertion_list_top.sv -----
// Testbench for the sorted insertion list: a directed table, then random command runs.
`timescale 1ns / 100ps

module tb_sorted_insertion_list_top;
   import sil_pkg::*;

   localparam int LIST_DEPTH   = CAPACITY_DEF;
   localparam int RANDOM_WORDS = 1800;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 80;
   localparam int DRAIN_WAIT   = 10;
   localparam int COUNT_LSB    = VALUE_W;
   localparam int STATUS_LSB   = VALUE_W + COUNT_W;

   // Command code 3 is unused by the block and must leave the list alone.
   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

   // Fields of one response word.
   typedef struct packed {
      logic [VALUE_W-1:0] rd;
      logic [COUNT_W-1:0] cnt;
      status_type         st;
   } outcome_type;

   // One command word, with an optional hand-written expected outcome.
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic               fixed;
      outcome_type        outcome;
   } command_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // value[31:0], index[35:32], zero pad
   logic [CMD_W-1:0]      req_tuser  = '0;  // cmd[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // read_value[31:0], count[36:32],
                                            // status[38:37], zero pad

   // Hand-written expectation travelling alongside the word on offer.
   logic        offer_fixed   = 1'b0;
   outcome_type offer_outcome = '0;

   // Shadow of the list contents, kept in ascending order.
   logic signed [VALUE_W-1:0] held[$];
   outcome_type               pending_outcomes[$];
   command_type               directed_cmds[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit long_hold_due = 1'b0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int failures      = 0;
   int words_in      = 0;
   int words_out     = 0;
   int full_seen     = 0;
   int absent_seen   = 0;
   int range_seen    = 0;

   sorted_insertion_list_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one command to the shadow list and returns the outcome it should give.
   function automatic outcome_type apply_to_list(input logic [CMD_W-1:0] cmd,
                                                 input logic signed [VALUE_W-1:0] value,
                                                 input logic [INDEX_W-1:0] index);
      outcome_type o;
      int          pos;
      o.rd = '0;
      o.st = ST_OK;
      case (cmd)
         CMD_INSERT: begin
            if (held.size() >= LIST_DEPTH) begin
               o.st = ST_FULL;
            end else begin
               // The new entry goes after every entry that is not greater.
               pos = 0;
               while (pos < held.size() && held[pos] <= value) pos++;
               held.insert(pos, value);
            end
         end
         CMD_REMOVE: begin
            // The first equal entry is the one taken out.
            pos = 0;
            while (pos < held.size() && held[pos] != value) pos++;
            if (pos == held.size()) o.st = ST_NOT_FOUND;
            else held.delete(pos);
         end
         CMD_READ: begin
            if (index >= held.size()) o.st = ST_RANGE;
            else o.rd = held[index];
         end
         default: ;
      endcase
      o.cnt = COUNT_W'(held.size());
      return o;
   endfunction

   task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                          input logic [INDEX_W-1:0] index, input logic fixed,
                          input logic [VALUE_W-1:0] rd, input logic [COUNT_W-1:0] cnt,
                          input status_type st);
      command_type c;
      c.cmd     = cmd;
      c.value   = value;
      c.index   = index;
      c.fixed   = fixed;
      c.outcome = {rd, cnt, st};
      directed_cmds.insert(directed_cmds.size(), c);
   endtask

   task automatic report_field(input string field, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
      failures++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
   endtask

   // Predicts each accepted command word and checks each accepted response word.
   always @(posedge clock) begin : score_words
      outcome_type want;
      outcome_type got;
      if (!reset && req_tvalid && req_tready) begin
         want = apply_to_list(req_tuser, req_tdata[VALUE_W-1:0],
                              req_tdata[VALUE_W+INDEX_W-1:VALUE_W]);
         if (offer_fixed) want = offer_outcome;
         pending_outcomes.insert(pending_outcomes.size(), want);
         words_in++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.rd  = rsp_tdata[VALUE_W-1:0];
         got.cnt = rsp_tdata[COUNT_LSB+COUNT_W-1:COUNT_LSB];
         got.st  = status_type'(rsp_tdata[STATUS_LSB+STATUS_W-1:STATUS_LSB]);
         words_out++;
         if (got.st == ST_FULL) full_seen++;
         if (got.st == ST_NOT_FOUND) absent_seen++;
         if (got.st == ST_RANGE) range_seen++;
         if (pending_outcomes.size() == 0) begin
            failures++;
            $display("%0t: response word with none expected: expected nothing, actual %h",
                     $time, rsp_tdata);
         end else begin
            want = pending_outcomes.pop_front();
            if (got.rd !== want.rd) report_field("read_value", want.rd, got.rd);
            if (got.cnt !== want.cnt)
               report_field("count", VALUE_W'(want.cnt), VALUE_W'(got.cnt));
            if (got.st !== want.st)
               report_field("status", VALUE_W'(want.st), VALUE_W'(got.st));
         end
      end
   end

   // Receiver: random stalls, and now and then one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one word, after some random idle cycles, and waits until it is taken.
   task automatic offer_word(input command_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tuser     <= c.cmd;
      req_tdata     <= {{(REQ_DATA_W-VALUE_W-INDEX_W){1'b0}}, c.index, c.value};
      offer_fixed   <= c.fixed;
      offer_outcome <= c.outcome;
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds the sender back until every expected response word has come.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Values cluster around zero so that duplicates and hits are common.
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      int                 kind;
      kind = $urandom_range(9);
      if (kind < 4) begin
         v = $urandom_range(16);
         v = v - 8;
      end else if (kind == 4) begin
         v = $urandom_range(3);
         v = v + 32'h8000_0000;
      end else if (kind == 5) begin
         v = $urandom_range(3);
         v = 32'h7fff_ffff - v;
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   // Mostly a value that is held, sometimes one that is probably not.
   function automatic logic [VALUE_W-1:0] pick_removal();
      if (held.size() > 0 && $urandom_range(99) < 85)
         return held[$urandom_range(held.size() - 1)];
      return pick_value();
   endfunction

   // Random runs: fill to overflow, drain, read sweeps and mixed traffic.
   task automatic run_random(input int words);
      command_type c;
      int          done;
      int          n;
      int          kind;
      int          start;
      int          sel;
      done = 0;
      while (done < words) begin
         kind = (done == 0) ? 0 : $urandom_range(9);
         if (kind <= 2) n = LIST_DEPTH - held.size() + $urandom_range(1, 3);
         else if (kind <= 4) n = held.size() + $urandom_range(1, 2);
         else if (kind <= 6) n = $urandom_range(4, 18);
         else n = $urandom_range(5, 30);
         start = $urandom_range(15);
         for (int k = 0; k < n; k++) begin
            c       = '0;
            c.value = $urandom;
            c.index = INDEX_W'($urandom_range(15));
            if (kind <= 2) begin
               c.cmd   = CMD_INSERT;
               c.value = pick_value();
            end else if (kind <= 4) begin
               c.cmd   = CMD_REMOVE;
               c.value = pick_removal();
            end else if (kind <= 6) begin
               c.cmd   = CMD_READ;
               c.index = INDEX_W'(start + k);
            end else begin
               sel = $urandom_range(99);
               if (sel < 40) begin
                  c.cmd   = CMD_INSERT;
                  c.value = pick_value();
               end else if (sel < 70) begin
                  c.cmd   = CMD_REMOVE;
                  c.value = pick_removal();
               end else if (sel < 95) begin
                  c.cmd = CMD_READ;
               end else begin
                  c.cmd = CMD_NOP;
               end
            end
            if (done == words / 2) long_hold_due = 1'b1;
            offer_word(c);
            done++;
         end
      end
   endtask

   // Run limit.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d response words outstanding",
               cycle_count, pending_outcomes.size());
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table; rows with a typed outcome are the obvious ones.
      add_row(CMD_READ,   32'd0,         4'd0,  1'b1, 32'd0, 5'd0, ST_RANGE);
      add_row(CMD_REMOVE, 32'd5,         4'd0,  1'b1, 32'd0, 5'd0, ST_NOT_FOUND);
      add_row(CMD_NOP,    32'hffff_ffff, 4'd15, 1'b1, 32'd0, 5'd0, ST_OK);
      add_row(CMD_INSERT, 32'h7fff_ffff, 4'd15, 1'b1, 32'd0, 5'd1, ST_OK);
      add_row(CMD_INSERT, 32'h8000_0000, 4'd0,  1'b1, 32'd0, 5'd2, ST_OK);
      add_row(CMD_INSERT, 32'd7,         4'd0,  1'b0, 32'd0, 5'd0, ST_OK);
      add_row(CMD_INSERT, 32'd7,         4'd0,  1'b0, 32'd0, 5'd0, ST_OK);
      add_row(CMD_INSERT, 32'hffff_fff9, 4'd0,  1'b0, 32'd0, 5'd0, ST_OK);
      add_row(CMD_INSERT, 32'hffff_ffff, 4'd0,  1'b0, 32'd0, 5'd0, ST_OK);
      add_row(CMD_INSERT, 32'd0,         4'd0,  1'b0, 32'd0, 5'd0, ST_OK);
      add_row(CMD_READ,   32'd0,         4'd0,  1'b1, 32'h8000_0000, 5'd7, ST_OK);
      add_row(CMD_READ,   32'd0,         4'd6,  1'b1, 32'h7fff_ffff, 5'd7, ST_OK);
      add_row(CMD_READ,   32'd0,         4'd7,  1'b1, 32'd0, 5'd7, ST_RANGE);
      add_row(CMD_READ,   32'hffff_ffff, 4'd15, 1'b1, 32'd0, 5'd7, ST_RANGE);
      add_row(CMD_READ,   32'd0,         4'd3,  1'b0, 32'd0, 5'd0, ST_OK);
      add_row(CMD_REMOVE, 32'd7,         4'd0,  1'b0, 32'd0, 5'd0, ST_OK);
      add_row(CMD_REMOVE, 32'd100,       4'd0,  1'b1, 32'd0, 5'd6, ST_NOT_FOUND);
      add_row(CMD_REMOVE, 32'h8000_0000, 4'd0,  1'b0, 32'd0, 5'd0, ST_OK);
      add_row(CMD_REMOVE, 32'h7fff_ffff, 4'd0,  1'b0, 32'd0, 5'd0, ST_OK);
      add_row(CMD_READ,   32'd0,         4'd2,  1'b0, 32'd0, 5'd0, ST_OK);
      add_row(CMD_NOP,    32'd0,         4'd0,  1'b1, 32'd0, 5'd4, ST_OK);

      send_idle_pct = 14;
      recv_idle_pct = 46;
      foreach (directed_cmds[i]) offer_word(directed_cmds[i]);
      wait_drained();
      run_random(RANDOM_WORDS / 3);
      wait_drained();

      send_idle_pct = 46;
      recv_idle_pct = 14;
      run_random(RANDOM_WORDS / 3);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_WORDS / 3);
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      failures += pending_outcomes.size();
      $display("Sent %0d command words (%0d from the table), checked %0d response words.",
               words_in, directed_cmds.size(), words_out);
      $display("Outcomes seen: %0d list full, %0d value not found, %0d index out of range.",
               full_seen, absent_seen, range_seen);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
